[rtl/range_flip_range_popcount_macros.svh]
// Assertion macros shared by the range flip and popcount RTL.
`ifndef RANGE_FLIP_RANGE_POPCOUNT_MACROS_SVH
`define RANGE_FLIP_RANGE_POPCOUNT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RFRP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked out of reset.
`define RFRP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[rtl/rfrp_pkg.sv]
// Shared widths, codes and the command type of the range flip and popcount block.
package rfrp_pkg;

  localparam int IDX_W          = 11;
  localparam int CNT_W          = 11;
  localparam int DEF_MAX_LEN    = 1024;
  localparam int DEF_BLOCK_SIZE = 32;
  localparam int Q_DEPTH        = 2;
  localparam logic [IDX_W-1:0] LEN_RESET = 11'd1024;

  localparam logic REQ_FLIP  = 1'b0;
  localparam logic REQ_COUNT = 1'b1;

  typedef struct packed {
    logic             err;
    logic             req;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } cmd_t;

endpackage

[rtl/rfrp_front.sv]
// Front end: checks the range of each request and turns it into a zero-based command.
module rfrp_front
  import rfrp_pkg::*;
#(
  parameter int MAX_LEN = DEF_MAX_LEN
) (
  input  logic             req_type,
  input  logic [IDX_W-1:0] left_index,
  input  logic [IDX_W-1:0] right_index,
  input  logic [IDX_W-1:0] active_length,
  output cmd_t             cmd
);

  logic [IDX_W-1:0] len_eff;

  // The usable length never exceeds the physical store.
  assign len_eff = (32'(active_length) > 32'(MAX_LEN)) ? IDX_W'(MAX_LEN) : active_length;

  always_comb begin
    cmd.err = (left_index == '0) || (left_index > right_index) || (right_index > len_eff);
    cmd.req = req_type;
    cmd.lo  = left_index - IDX_W'(1);
    cmd.hi  = right_index - IDX_W'(1);
  end

endmodule

[rtl/rfrp_queue.sv]
// Short command queue between the front end and the block engine.
module rfrp_queue
  import rfrp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int PTR_W = $clog2(Q_DEPTH);

  cmd_t             entry_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             push, pop;

  assign push_ready = (count_r != (PTR_W+1)'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      count_r <= count_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

[rtl/rfrp_back.sv]
// Block engine: walks the blocks of one command, using block marks inside and rows at the edges.
module rfrp_back
  import rfrp_pkg::*;
#(
  parameter int MAX_LEN    = DEF_MAX_LEN,
  parameter int BLOCK_SIZE = DEF_BLOCK_SIZE
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CNT_W-1:0] out_count,
  output logic             out_err
);

`include "range_flip_range_popcount_macros.svh"

  localparam int NB     = (MAX_LEN + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int ROW_W  = (NB > 1) ? $clog2(NB) : 1;
  localparam int OFF_W  = $clog2(BLOCK_SIZE);
  localparam int ONES_W = $clog2(BLOCK_SIZE + 1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_EXEC, S_DONE} state_t;

  function automatic logic [ONES_W-1:0] popcnt(input logic [BLOCK_SIZE-1:0] v);
    logic [ONES_W-1:0] s;
    s = '0;
    for (int j = 0; j < BLOCK_SIZE; j++) s = s + ONES_W'(v[j]);
    return s;
  endfunction

  state_t            st_r;
  cmd_t              cmd_r;
  logic [ROW_W-1:0]  b_r;
  logic [CNT_W-1:0]  acc_r;
  logic              err_r;
  logic              out_valid_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_err_r;
  logic              inv_r  [NB];
  logic              rvld_r [NB];
  logic [ONES_W-1:0] ones_r [NB];

  logic [BLOCK_SIZE-1:0] mem [NB];
  logic [BLOCK_SIZE-1:0] rdata_r;
  logic                  rdata_vld_r;

  logic [ROW_W-1:0]      lb, rb;
  logic                  is_edge;
  logic [OFF_W-1:0]      lo_off, hi_off;
  logic [BLOCK_SIZE-1:0] mask, row, new_row;
  logic [CNT_W-1:0]      total;
  logic                  mem_we;
  logic                  out_free;

  assign lb       = ROW_W'(cmd_r.lo / BLOCK_SIZE);
  assign rb       = ROW_W'(cmd_r.hi / BLOCK_SIZE);
  assign is_edge  = (b_r == lb) || (b_r == rb);
  assign lo_off   = (b_r == lb) ? OFF_W'(cmd_r.lo % BLOCK_SIZE) : '0;
  assign hi_off   = (b_r == rb) ? OFF_W'(cmd_r.hi % BLOCK_SIZE) : OFF_W'(BLOCK_SIZE - 1);
  assign out_free = !out_valid_r || out_ready;
  assign cmd_ready = (st_r == S_IDLE);

  always_comb begin
    for (int j = 0; j < BLOCK_SIZE; j++) begin
      mask[j] = (OFF_W'(j) >= lo_off) && (OFF_W'(j) <= hi_off);
    end
    // A row never written reads as zero; the pending inversion is applied here.
    row     = (rdata_vld_r ? rdata_r : '0) ^ {BLOCK_SIZE{inv_r[b_r]}};
    new_row = row ^ mask;
    total   = inv_r[b_r] ? CNT_W'(BLOCK_SIZE) - CNT_W'(ones_r[b_r]) : CNT_W'(ones_r[b_r]);
    mem_we  = (st_r == S_EXEC) && (cmd_r.req == REQ_FLIP);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[b_r] <= new_row;
    if (st_r == S_WALK) rdata_r <= mem[b_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NB; k++) begin
        inv_r[k]  <= 1'b0;
        rvld_r[k] <= 1'b0;
        ones_r[k] <= '0;
      end
    end else begin
      if (st_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            b_r   <= ROW_W'(cmd.lo / BLOCK_SIZE);
            acc_r <= '0;
            err_r <= cmd.err;
            st_r  <= cmd.err ? S_DONE : S_WALK;
          end
        end
        S_WALK: begin
          if (is_edge) begin
            rdata_vld_r <= rvld_r[b_r];
            st_r        <= S_EXEC;
          end else begin
            if (cmd_r.req == REQ_FLIP) inv_r[b_r] <= !inv_r[b_r];
            else acc_r <= acc_r + total;
            b_r <= b_r + ROW_W'(1);
          end
        end
        S_EXEC: begin
          if (cmd_r.req == REQ_FLIP) begin
            rvld_r[b_r] <= 1'b1;
            inv_r[b_r]  <= 1'b0;
            ones_r[b_r] <= popcnt(new_row);
          end else begin
            acc_r <= acc_r + CNT_W'(popcnt(row & mask));
          end
          if (b_r == rb) begin
            st_r <= (cmd_r.req == REQ_FLIP) ? S_IDLE : S_DONE;
          end else begin
            b_r  <= b_r + ROW_W'(1);
            st_r <= S_WALK;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_count_r <= acc_r;
            out_err_r   <= err_r;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;
  assign out_err   = out_err_r;

  `RFRP_ASSERT_IMP(a_exec_on_edge, st_r == S_EXEC, is_edge)
  `RFRP_ASSERT_IMP(a_err_no_count, st_r == S_DONE && err_r, acc_r == '0)
  `RFRP_ASSERT_NXT(a_edge_settled, st_r == S_EXEC && cmd_r.req == REQ_FLIP,
                   !inv_r[$past(b_r)] && rvld_r[$past(b_r)])

endmodule

[rtl/range_flip_range_popcount.sv]
// Top level of the range flip and range popcount block.
// The block holds a bit array, positions 1 to active_length, cleared at reset, kept as
// rows of BLOCK_SIZE bits in a memory together with a ones count and a pending-invert
// mark per row. A flip item inverts a range and gives no result; a count item returns
// the number of ones in its range; an item whose range is empty, starts below 1 or
// runs past active_length changes nothing and returns one result with the error flag
// set and a count of zero. Items are checked on entry and queued two deep, so the
// input accepts while the engine works or a result waits, until the queue is full.
// The engine handles one item at a time: an invalid item goes straight to the result
// step; a valid one walks its blocks, visiting one interior block per cycle, while
// each edge row is read from memory and then updated, and a count ends with a step
// that loads its result. Writing active_length leaves stored bits untouched; it is
// to be written only while the block is idle.
module range_flip_range_popcount
  import rfrp_pkg::*;
#(
  parameter int MAX_LEN    = DEF_MAX_LEN,
  parameter int BLOCK_SIZE = DEF_BLOCK_SIZE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // left_index [10:0], right_index [21:11], zeros above
  input  logic        in_tuser,   // req_type: 0 flip, 1 count
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // ones_count [10:0], zeros above
  output logic        out_tuser,  // range_error
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data // active_length
);

  logic [IDX_W-1:0] active_length_r;
  cmd_t             front_cmd, q_cmd;
  logic             q_valid, q_ready;
  logic [CNT_W-1:0] ones_count;

  // The single configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_length_r <= LEN_RESET;
    end else if (cfg_wr_en) begin
      active_length_r <= cfg_wr_data;
    end
  end

  // Classify each item as it arrives.
  rfrp_front #(.MAX_LEN(MAX_LEN)) u_front (
    .req_type      (in_tuser),
    .left_index    (in_tdata[10:0]),
    .right_index   (in_tdata[21:11]),
    .active_length (active_length_r),
    .cmd           (front_cmd)
  );

  // The queue's free space is what the input channel sees as ready.
  rfrp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_data  (front_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  // The engine owns the bit rows, the block marks and the output register.
  rfrp_back #(.MAX_LEN(MAX_LEN), .BLOCK_SIZE(BLOCK_SIZE)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_count (ones_count),
    .out_err   (out_tuser)
  );

  assign out_tdata = {5'b0, ones_count};

endmodule
